// File: rtl/klp_pkg.sv
// Shared types and constants for the key click / long-press detector.
package klp_pkg;

   // Default number of keys held in the state memory
   localparam int KEYS_DEFAULT = 8;

   // Field widths
   localparam int KEY_W   = 3;
   localparam int CODE_W  = 3;
   localparam int CNT_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT     = 2'd2;

   // Register reset values
   localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [CNT_W-1:0] LONG_PRESS_RESET = 16'd100;
   localparam logic [CNT_W-1:0] REPEAT_RESET     = 16'd20;

   // Per-key phase
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_DEBOUNCE = 3'd1,
      PH_HOLD     = 3'd2,
      PH_LONG     = 3'd3,
      PH_RELEASED = 3'd4
   } phase_type;

   // Event codes
   typedef enum logic [CODE_W-1:0] {
      EV_CLICK         = 3'd0,
      EV_LONG_PRESS    = 3'd1,
      EV_CLICK_RELEASE = 3'd2,
      EV_LONG_RELEASE  = 3'd3,
      EV_REPEAT        = 3'd4
   } event_code_type;

   // One memory entry per key; only the count of the current phase is ever
   // nonzero, so a single counter serves all three timing phases.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      phase_type        phase;
   } key_entry_type;

   localparam int ENTRY_W = $bits(key_entry_type);

   localparam key_entry_type ENTRY_RESET = '{count: '0, phase: PH_IDLE};

   // Event produced by the key machine
   typedef struct packed {
      logic           fire;
      event_code_type code;
   } key_event_type;

   // Item stored in the result queue
   typedef struct packed {
      event_code_type   code;
      logic [KEY_W-1:0] key;
   } rsp_item_type;

   // Thresholds from the configuration registers
   typedef struct packed {
      logic [CNT_W-1:0] debounce;
      logic [CNT_W-1:0] long_press;
      logic [CNT_W-1:0] repeat_ticks;
   } thresholds_type;

endpackage

// File: rtl/key_click_long_press_detector.sv
// Top level of the per-key click, long-press and auto-repeat detector.
// Each accepted item is one tick's sample of one key line (0 = pressed).
// The state of every key (phase and tick counter) lives in one RAM with a
// registered read: the key is read when the item is accepted, updated in the
// next cycle and written back, and the entry written in that cycle is
// forwarded to a following item of the same key. One item is taken every
// clock cycle while req_tready is high; an event reaches the rsp_ side through
// the update stage and a four-entry queue. req_tready drops only when that
// queue, counting the item still being updated, holds three items.
// A valid bit per key, cleared by reset, makes every key start idle, so no
// clearing pass is needed. Samples for a key index not below KEYS are
// dropped without an event. Thresholds of zero act as one.
module key_click_long_press_detector #(
   parameter int KEYS = klp_pkg::KEYS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: [2:0] key_index, [3] line_level, [7:4] zero
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [klp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: [2:0] event_key, [5:3] event_code, [7:6] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [klp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [klp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [klp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import klp_pkg::*;

   localparam int AW = (KEYS > 1) ? $clog2(KEYS) : 1;

   // Configuration registers
   logic [CNT_W-1:0] debounce_ff, long_press_ff, repeat_ff;

   // Update stage
   logic             s1_valid_ff;
   logic [AW-1:0]    s1_addr_ff;
   logic [KEY_W-1:0] s1_key_ff;
   logic             s1_line_ff;

   // Forwarding of the entry written at the same edge as the current read
   logic             fwd_valid_ff;
   logic [AW-1:0]    fwd_addr_ff;
   key_entry_type    fwd_data_ff;

   // Per-key valid bits
   logic [KEYS-1:0]  valid_ff;

   logic [KEY_W-1:0] req_key;
   logic             req_line;
   logic [8:0]       req_key_ext;
   logic             key_in_range;
   logic [AW-1:0]    req_addr;
   logic             accept;

   logic [ENTRY_W-1:0] ram_rd_data;
   key_entry_type    cur_entry;
   key_entry_type    nxt_entry;
   key_event_type    evt;
   thresholds_type   thr;

   rsp_item_type     push_item;
   rsp_item_type     pop_item;
   logic [2:0]       fifo_level;

   // Input fields and address
   assign req_key      = req_tdata[KEY_W-1:0];
   assign req_line     = req_tdata[KEY_W];
   assign req_key_ext  = {6'b000000, req_key};
   assign key_in_range = (req_key_ext < 9'(KEYS));
   assign req_addr     = req_key_ext[AW-1:0];

   // Room for the item in flight plus a new one, with the queue draining
   assign req_tready = ({1'b0, fifo_level} + {3'b000, s1_valid_ff}) <= 4'd2;
   assign accept     = req_tvalid & req_tready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
         repeat_ff     <= REPEAT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            CSR_REPEAT:     repeat_ff     <= csr_wdata;
            default:        ;
         endcase
      end
   end

   assign thr = '{debounce: debounce_ff, long_press: long_press_ff,
                  repeat_ticks: repeat_ff};

   // Stage register: item whose entry is being read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept & key_in_range;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= req_addr;
      s1_key_ff  <= req_key;
      s1_line_ff <= req_line;
   end

   // Key state memory
   klp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEYS),
      .AW    (AW)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (nxt_entry),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // Entry select: forwarded write, then memory, then reset value
   always_comb begin
      priority if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         cur_entry = fwd_data_ff;
      end else if (valid_ff[s1_addr_ff]) begin
         cur_entry = key_entry_type'(ram_rd_data);
      end else begin
         cur_entry = ENTRY_RESET;
      end
   end

   klp_key_fsm u_key_fsm (
      .cur        (cur_entry),
      .line_level (s1_line_ff),
      .thr        (thr),
      .nxt        (nxt_entry),
      .evt        (evt)
   );

   // Forwarding register and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         fwd_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            valid_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= nxt_entry;
   end

   // Result queue
   assign push_item = '{code: evt.code, key: s1_key_ff};

   klp_event_fifo u_event_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff & evt.fire),
      .push_item (push_item),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_item  (pop_item),
      .level     (fifo_level)
   );

   assign rsp_tdata = {2'b00, pop_item.code, pop_item.key};

endmodule

// File: rtl/klp_ram.sv
// Generic single write port, single read port RAM with registered read.
module klp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/klp_key_fsm.sv
// Per-key phase machine: next entry and event from the current entry and line.
module klp_key_fsm (
   input  klp_pkg::key_entry_type  cur,
   input  logic                    line_level,
   input  klp_pkg::thresholds_type thr,
   output klp_pkg::key_entry_type  nxt,
   output klp_pkg::key_event_type  evt
);
   import klp_pkg::*;

   logic             low;
   logic [CNT_W:0]   cnt_inc;
   logic [CNT_W-1:0] limit;
   logic             reach;

   assign low = ~line_level;

   // Threshold of the current phase; zero acts as one through the >= compare
   always_comb begin
      unique case (cur.phase)
         PH_DEBOUNCE: limit = thr.debounce;
         PH_HOLD:     limit = thr.long_press;
         PH_LONG:     limit = thr.repeat_ticks;
         default:     limit = thr.repeat_ticks;
      endcase
   end

   assign cnt_inc = {1'b0, cur.count} + {{CNT_W{1'b0}}, 1'b1};
   assign reach   = (cnt_inc >= {1'b0, limit});

   // Next state
   always_comb begin
      nxt = cur;
      unique case (cur.phase)
         PH_DEBOUNCE: begin
            if (!low) begin
               nxt = '{count: '0, phase: PH_IDLE};
            end else if (reach) begin
               nxt = '{count: '0, phase: PH_HOLD};
            end else begin
               nxt.count = cnt_inc[CNT_W-1:0];
            end
         end
         PH_HOLD: begin
            if (!low) begin
               nxt = '{count: '0, phase: PH_RELEASED};
            end else if (reach) begin
               nxt = '{count: '0, phase: PH_LONG};
            end else begin
               nxt.count = cnt_inc[CNT_W-1:0];
            end
         end
         PH_LONG: begin
            if (!low) begin
               nxt = '{count: '0, phase: PH_RELEASED};
            end else if (reach) begin
               nxt.count = '0;
            end else begin
               nxt.count = cnt_inc[CNT_W-1:0];
            end
         end
         PH_RELEASED: begin
            if (!low) begin
               nxt.phase = PH_IDLE;
            end
         end
         default: begin
            // idle, and any stray code
            if (low) begin
               nxt.phase = PH_DEBOUNCE;
            end
         end
      endcase
   end

   // Outputs
   always_comb begin
      evt = '{fire: 1'b0, code: EV_CLICK};
      unique case (cur.phase)
         PH_DEBOUNCE: begin
            if (low && reach) begin
               evt = '{fire: 1'b1, code: EV_CLICK};
            end
         end
         PH_HOLD: begin
            if (!low) begin
               evt = '{fire: 1'b1, code: EV_CLICK_RELEASE};
            end else if (reach) begin
               evt = '{fire: 1'b1, code: EV_LONG_PRESS};
            end
         end
         PH_LONG: begin
            if (!low) begin
               evt = '{fire: 1'b1, code: EV_LONG_RELEASE};
            end else if (reach) begin
               evt = '{fire: 1'b1, code: EV_REPEAT};
            end
         end
         default: begin
            evt = '{fire: 1'b0, code: EV_CLICK};
         end
      endcase
   end

endmodule

// File: rtl/klp_event_fifo.sv
// Four-entry result queue between the update stage and the output channel.
module klp_event_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  klp_pkg::rsp_item_type push_item,
   input  logic                  pop_ready,
   output logic                  pop_valid,
   output klp_pkg::rsp_item_type pop_item,
   output logic [2:0]            level
);
   import klp_pkg::*;

   rsp_item_type slots_ff [4];
   logic [1:0]   wr_ptr_ff, wr_ptr_in;
   logic [1:0]   rd_ptr_ff, rd_ptr_in;
   logic [2:0]   count_ff, count_in;
   logic         pop;

   assign pop_valid = (count_ff != 3'd0);
   assign pop       = pop_valid & pop_ready;
   assign pop_item  = slots_ff[rd_ptr_ff];
   assign level     = count_ff;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'b00, push} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
